// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL top, html_syntax_classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define HSC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define HSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/hsc_pkg.sv -----
// Types, codes and character constants of the HTML syntax classifier.
package hsc_pkg;

	localparam int CHAR_W        = 16;
	localparam int CHAR_BITS_DEF = 16;

	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_TAG     = 2'd1,
		MODE_COMMENT = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		Q_NONE   = 2'd0,
		Q_DOUBLE = 2'd1,
		Q_SINGLE = 2'd2
	} quote_t;

	typedef enum logic [1:0] {
		CLS_NORMAL  = 2'd0,
		CLS_ENTITY  = 2'd1,
		CLS_TAG     = 2'd2,
		CLS_COMMENT = 2'd3
	} class_t;

	typedef struct packed {
		mode_t      mode;
		logic       entity;
		quote_t     quote;
		logic [1:0] tail;
	} lex_state_t;

	localparam lex_state_t LEX_RESET = '{
		mode: MODE_NORMAL, entity: 1'b0, quote: Q_NONE, tail: 2'd0
	};

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              line_end;
	} text_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic [1:0]        char_class;
		logic              out_line_end;
		logic              run_last;
	} tag_item_t;

	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_DQ   = 8'h22;
	localparam logic [7:0] CH_SQ   = 8'h27;

endpackage

// ----- rtl/hsc_classify.sv -----
// Lexer rules: class of the oldest window character and the next lexer state.
module hsc_classify #(
	parameter int CHAR_BITS = hsc_pkg::CHAR_BITS_DEF
) (
	input  hsc_pkg::lex_state_t        cur,
	input  logic [3:0][CHAR_BITS-1:0]  win,
	input  logic [2:0]                 avail,
	output hsc_pkg::class_t            cls,
	output hsc_pkg::lex_state_t        nxt
);
	import hsc_pkg::*;

	function automatic logic is_ch(logic [CHAR_BITS-1:0] x, logic [7:0] c);
		return x == CHAR_BITS'(c);
	endfunction

	logic open_match;
	logic close_match;
	logic [CHAR_BITS-1:0] ch;

	assign ch = win[0];

	// patterns never match across the line end
	assign open_match = (avail >= 3'd4) && is_ch(win[0], CH_LT) && is_ch(win[1], CH_BANG)
		&& is_ch(win[2], CH_DASH) && is_ch(win[3], CH_DASH);
	assign close_match = (avail >= 3'd3) && is_ch(win[0], CH_DASH)
		&& is_ch(win[1], CH_DASH) && is_ch(win[2], CH_GT);

	always_comb begin
		nxt = cur;
		cls = CLS_NORMAL;
		case (cur.mode)
			MODE_COMMENT: begin
				cls = CLS_COMMENT;
				if (cur.tail != 2'd0) begin
					nxt.tail = cur.tail - 2'd1;
					if (cur.tail == 2'd1)
						nxt.mode = MODE_NORMAL;
				end else if (close_match) begin
					nxt.tail = 2'd2;
				end
			end
			MODE_TAG: begin
				cls = CLS_TAG;
				if (cur.quote == Q_DOUBLE) begin
					if (is_ch(ch, CH_DQ))
						nxt.quote = Q_NONE;
				end else if (cur.quote == Q_SINGLE) begin
					if (is_ch(ch, CH_SQ))
						nxt.quote = Q_NONE;
				end else if (is_ch(ch, CH_DQ)) begin
					nxt.quote = Q_DOUBLE;
				end else if (is_ch(ch, CH_SQ)) begin
					nxt.quote = Q_SINGLE;
				end else if (is_ch(ch, CH_GT)) begin
					nxt.quote = Q_NONE;
					nxt.mode  = MODE_NORMAL;
				end else begin
					nxt.quote = Q_NONE;
				end
			end
			default: begin
				nxt.mode = MODE_NORMAL;
				if (cur.entity) begin
					cls = CLS_ENTITY;
					if (is_ch(ch, CH_SEMI))
						nxt.entity = 1'b0;
				end else if (is_ch(ch, CH_LT)) begin
					if (open_match) begin
						cls      = CLS_COMMENT;
						nxt.mode = MODE_COMMENT;
						nxt.tail = 2'd0;
					end else begin
						cls       = CLS_TAG;
						nxt.mode  = MODE_TAG;
						nxt.quote = Q_NONE;
					end
				end else if (is_ch(ch, CH_AMP)) begin
					cls        = CLS_ENTITY;
					nxt.entity = 1'b1;
				end
			end
		endcase
	end

endmodule

// ----- rtl/hsc_out_reg.sv -----
// Result register: holds one classified item until the receiver takes it.
module hsc_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  hsc_pkg::tag_item_t din,
	input  logic               stall,
	output logic               valid,
	output hsc_pkg::tag_item_t dout,
	output logic               ready
);
	import hsc_pkg::*;

	logic      valid_q;
	tag_item_t data_q;

	assign ready = !valid_q || !stall;
	assign valid = valid_q;
	assign dout  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load)
			data_q <= din;
	end

endmodule

// ----- rtl/html_syntax_classifier.sv -----
// HTML syntax classifier: tags each text character normal, entity, tag or comment.
// Characters enter one per cycle on the text channel while text_stall is low and leave
// with their class on the tag channel. Within a line a character's class needs the three
// characters after it, so its result appears once the third following character is taken;
// the line-end character flushes every held character of the line, one result per cycle
// while tag_stall is low, so a line end that finds n characters (1 to 4) held yields n
// results, and every other character yields at most one. The mode (normal, tag, comment)
// carries across lines; entity and quote state end at each line end. An input register
// and a result register part the two channels.
module html_syntax_classifier #(
	parameter int CHAR_BITS = hsc_pkg::CHAR_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                text_valid,
	output logic                text_stall,
	input  hsc_pkg::text_item_t text_data,
	output logic                tag_valid,
	input  logic                tag_stall,
	output hsc_pkg::tag_item_t  tag_data
);
	import hsc_pkg::*;

	localparam int COMMON_BITS = (CHAR_BITS < CHAR_W) ? CHAR_BITS : CHAR_W;

	// input stage
	logic                 valid_s1;
	logic [CHAR_BITS-1:0] ch_s1;
	logic                 end_s1;

	// lookahead window and lexer state
	logic [2:0][CHAR_BITS-1:0] win_q;
	logic [1:0]                cnt_q;
	logic                      flush_q;
	lex_state_t                st_q;

	logic [3:0][CHAR_BITS-1:0] w;
	logic [2:0]                avail;
	logic                      line_mode;
	logic                      emit;
	logic                      do_step;
	logic                      consume;
	logic                      last_of_line;
	logic                      out_ready;
	class_t                    cls;
	lex_state_t                nst;
	lex_state_t                st_next;
	tag_item_t                 res;

	always_comb begin
		for (int i = 0; i < 3; i++)
			w[i] = (2'(i) < cnt_q) ? win_q[i] : ch_s1;
		w[3] = ch_s1;
	end

	assign avail        = {1'b0, cnt_q} + (flush_q ? 3'd0 : 3'd1);
	assign line_mode    = flush_q || end_s1;
	assign emit         = flush_q || end_s1 || (avail == 3'd4);
	assign do_step      = (flush_q || valid_s1) && (out_ready || !emit);
	assign consume      = do_step && !flush_q;
	assign last_of_line = line_mode && (avail == 3'd1);
	assign text_stall   = valid_s1 && !consume;

	hsc_classify #(.CHAR_BITS(CHAR_BITS)) u_classify (
		.cur   (st_q),
		.win   (w),
		.avail (avail),
		.cls   (cls),
		.nxt   (nst)
	);

	// entity, quote and comment tail end with the line; the mode carries over
	always_comb begin
		st_next = nst;
		if (last_of_line) begin
			st_next.entity = 1'b0;
			st_next.quote  = Q_NONE;
			st_next.tail   = 2'd0;
		end
	end

	always_comb begin
		res.out_char     = CHAR_W'(w[0][COMMON_BITS-1:0]);
		res.char_class   = cls;
		res.out_line_end = last_of_line;
		res.run_last     = !line_mode || last_of_line;
	end

	hsc_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (do_step && emit),
		.din    (res),
		.stall  (tag_stall),
		.valid  (tag_valid),
		.dout   (tag_data),
		.ready  (out_ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= 2'd0;
			flush_q  <= 1'b0;
			st_q     <= LEX_RESET;
		end else begin
			if (!valid_s1 || consume)
				valid_s1 <= text_valid;
			if (do_step) begin
				if (emit) begin
					cnt_q   <= 2'(avail - 3'd1);
					flush_q <= line_mode && !last_of_line;
					st_q    <= st_next;
				end else begin
					cnt_q <= avail[1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			ch_s1  <= CHAR_BITS'(text_data.char_code[COMMON_BITS-1:0]);
			end_s1 <= text_data.line_end;
		end
		if (do_step) begin
			for (int i = 0; i < 3; i++)
				win_q[i] <= emit ? w[i+1] : w[i];
		end
	end

`include "assert_macros.svh"

	`HSC_ASSERT(a_flush_holds, !flush_q || (cnt_q != 2'd0), "flush with empty window")
	`HSC_ASSERT(a_quote_in_tag, (st_q.quote == Q_NONE) || (st_q.mode == MODE_TAG), "quote outside tag")
	`HSC_ASSERT(a_tail_in_comment, (st_q.tail == 2'd0) || (st_q.mode == MODE_COMMENT), "tail outside comment")
	`HSC_ASSERT(a_line_end_last, !tag_valid || !tag_data.out_line_end || tag_data.run_last, "line end not last")
	`HSC_ASSERT_NEXT(a_flush_ends, flush_q && do_step && (cnt_q == 2'd1), !flush_q, "flush did not end")

endmodule
